>>> src/bdfd_pkg.sv
`timescale 1ns / 1ps

package bdfd_pkg;

	// Number of decimal length digits in a frame header (1..5)
	localparam int LEN_DIGITS = 4;

	localparam int BYTE_W = 8;
	localparam int CHAN_W = 4;
	localparam int LEN_W  = 14;
	localparam int POS_W  = 3;

	// Length register saturates here
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// Header positions
	localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
	localparam logic [POS_W-1:0] POS_TAG  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CHAN = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LEN0 = POS_W'(3);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(2 + LEN_DIGITS);

	// Header byte codes
	localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1B;
	localparam logic [BYTE_W-1:0] TAG_BYTE = 8'h5A;
	localparam logic [BYTE_W-1:0] CHR_0    = 8'h30;
	localparam logic [BYTE_W-1:0] CHR_9    = 8'h39;
	localparam logic [BYTE_W-1:0] CHR_A    = 8'h61;
	localparam logic [BYTE_W-1:0] CHR_F    = 8'h66;

	// Per-byte result flags, parse -> output stage
	typedef struct packed {
		logic              payload;
		logic              last;
		logic [CHAN_W-1:0] channel;
	} bdfd_res_t;

	function automatic logic is_dec(input logic [BYTE_W-1:0] b);
		return (b >= CHR_0) && (b <= CHR_9);
	endfunction

	function automatic logic is_hex(input logic [BYTE_W-1:0] b);
		return is_dec(b) || ((b >= CHR_A) && (b <= CHR_F));
	endfunction

	// Lowercase hex digit value; only meaningful when is_hex() holds
	function automatic logic [CHAN_W-1:0] hex_val(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = is_dec(b) ? (b - CHR_0) : (b - CHR_A + BYTE_W'(10));
		return v[CHAN_W-1:0];
	endfunction

endpackage

>>> src/bdfd_parse.sv
`timescale 1ns / 1ps

module bdfd_parse (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic [bdfd_pkg::BYTE_W-1:0]       data,
	output bdfd_pkg::bdfd_res_t               res
);
	import bdfd_pkg::*;

	logic [POS_W-1:0]  pos_q, pos_d;
	logic              inpay_q, inpay_d;
	logic [CHAN_W-1:0] chan_q, chan_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d;

	logic [POS_W-1:0]  pos_restart;
	logic [LEN_W-1:0]  acc;
	logic [LEN_W+3:0]  prod;
	logic [LEN_W-1:0]  len_new;
	logic [LEN_W-1:0]  cnt_inc;

	assign pos_restart = (data == ESC_BYTE) ? POS_TAG : POS_HUNT;

	// length accumulate: acc*10 + digit, saturating
	assign acc     = (pos_q == POS_LEN0) ? '0 : len_q;
	assign prod    = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
	                 + (LEN_W+4)'(data - CHR_0);
	assign len_new = (prod > (LEN_W+4)'(LEN_MAX)) ? LEN_MAX : prod[LEN_W-1:0];

	assign cnt_inc = (cnt_q < len_q) ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		pos_d       = pos_q;
		inpay_d     = inpay_q;
		chan_d      = chan_q;
		len_d       = len_q;
		cnt_d       = cnt_q;
		res.payload = 1'b0;
		res.last    = 1'b0;
		priority if (inpay_q) begin
			res.payload = 1'b1;
			cnt_d       = cnt_inc;
			if (cnt_inc >= len_q) begin
				res.last = 1'b1;
				inpay_d  = 1'b0;
			end
		end else if (pos_q == POS_HUNT) begin
			pos_d = pos_restart;
		end else if (pos_q == POS_TAG) begin
			pos_d = (data == TAG_BYTE) ? POS_CHAN : pos_restart;
		end else if (pos_q == POS_CHAN) begin
			if (is_hex(data)) begin
				chan_d = hex_val(data);
				pos_d  = POS_LEN0;
			end else begin
				pos_d = pos_restart;
			end
		end else if (pos_q <= POS_LAST && is_dec(data)) begin
			len_d = len_new;
			if (pos_q == POS_LAST) begin
				pos_d   = POS_HUNT;
				cnt_d   = '0;
				inpay_d = (len_new != '0);
			end else begin
				pos_d = pos_q + 1'b1;
			end
		end else begin
			pos_d = pos_restart;
		end
		res.channel = chan_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_HUNT;
			inpay_q <= 1'b0;
			chan_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (adv) begin
			pos_q   <= pos_d;
			inpay_q <= inpay_d;
			chan_q  <= chan_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

>>> src/bulk_data_frame_deframer.sv
`timescale 1ns / 1ps

// Bulk data frame deframer. Each received byte (rx_byte) yields exactly one
// output transfer carrying the byte unchanged plus framing flags. The block
// hunts for a header of ESC, 'Z', one lowercase hex channel digit and
// LEN_DIGITS decimal length digits; the following <length> bytes come out
// with payload_valid set, channel_id of that header, and frame_end on the
// last one. A zero length closes the frame with no payload bytes. While in
// payload every byte counts, ESC included. Throughput is one byte per clock
// while out_stall is low: a byte sits in an input register, the framing
// decision is made combinationally against the deframer state, and the
// result lands in an output register that drives out_valid and the fields.
// Both sides use valid/stall; in_stall rises only when both registers are
// full and out_stall is high.

module bulk_data_frame_deframer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [bdfd_pkg::BYTE_W-1:0]      rx_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             payload_valid,
	output logic [bdfd_pkg::BYTE_W-1:0]      payload_byte,
	output logic [bdfd_pkg::CHAN_W-1:0]      channel_id,
	output logic                             frame_end
);
	import bdfd_pkg::*;

	// stage 1: captured input byte
	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	// stage 2: result register
	logic              vld_s2;
	logic [BYTE_W-1:0] byte_s2;
	bdfd_res_t         res_s2;

	bdfd_res_t res;
	logic      load_s2;   // stage 1 byte moves to stage 2 (state advances)
	logic      load_s1;

	assign load_s2  = vld_s1 && (!vld_s2 || !out_stall);
	assign load_s1  = !vld_s1 || load_s2;
	assign in_stall = !load_s1;

	bdfd_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (load_s2),
		.data   (byte_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				vld_s1 <= in_valid;
			end
			if (load_s2) begin
				vld_s2 <= 1'b1;
			end else if (!out_stall) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1 <= rx_byte;
		end
		if (load_s2) begin
			byte_s2 <= byte_s1;
			res_s2  <= res;
		end
	end

	assign out_valid     = vld_s2;
	assign payload_valid = res_s2.payload;
	assign payload_byte  = byte_s2;
	assign channel_id    = res_s2.channel;
	assign frame_end     = res_s2.last;

endmodule

>>> verif/bulk_data_frame_deframer_tb.sv
`timescale 1ns / 1ps

// Each accepted rx_byte is run through a local copy of the deframer state.
// The local copy is the golden model, and each accepted byte queues exactly
// one expected output transfer. The output checker pops one per output
// transfer and compares every field.
module bulk_data_frame_deframer_tb;
	import bdfd_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int QUIET_LIMIT    = 5000;	// cycles with no transfer on either side
	localparam int HOLDOFF_CYCLES = 200;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 310;	// per traffic phase
	localparam int HDR_BYTES      = 3 + LEN_DIGITS;

	// Bytes right next to the accepted digit ranges, plus uppercase hex
	localparam logic [BYTE_W-1:0] CHR_UPPER_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CHR_SLASH    = 8'h2F;
	localparam logic [BYTE_W-1:0] CHR_COLON    = 8'h3A;
	localparam logic [BYTE_W-1:0] CHR_BACKTICK = 8'h60;
	localparam logic [BYTE_W-1:0] CHR_G        = 8'h67;

	typedef struct packed {
		logic              payload;
		logic [BYTE_W-1:0] data;
		logic [CHAN_W-1:0] chan;
		logic              last;
	} deframed_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              payload_valid;
	logic [BYTE_W-1:0] payload_byte;
	logic [CHAN_W-1:0] channel_id;
	logic              frame_end;

	// Local deframer state
	logic [POS_W-1:0]  hdr_pos;
	logic              in_frame;
	logic [CHAN_W-1:0] cur_chan;
	logic [LEN_W-1:0]  frame_len;
	logic [LEN_W-1:0]  frame_cnt;

	deframed_t deframed_q[$];
	deframed_t want_beat;
	int        errors = 0;
	int        sent_items = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        hold_left = 0;
	bit        hold_req = 1'b0;
	int        quiet_cycles = 0;

	bulk_data_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.channel_id    (channel_id),
		.frame_end     (frame_end)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// A bad header byte sends the hunt back to the start, or one step in if it is ESC
	function automatic logic [POS_W-1:0] hunt_restart(input logic [BYTE_W-1:0] b);
		return (b == ESC_BYTE) ? POS_TAG : POS_HUNT;
	endfunction

	// Advance the local deframer by one byte and return the transfer it should produce
	function automatic deframed_t deframe_byte(input logic [BYTE_W-1:0] b);
		deframed_t r;
		int        acc;
		r = '0;
		r.data = b;
		if (in_frame) begin
			// payload: every byte counts, ESC too
			r.payload = 1'b1;
			if (frame_cnt < frame_len)
				frame_cnt = frame_cnt + 1'b1;
			if (frame_cnt >= frame_len) begin
				r.last = 1'b1;
				in_frame = 1'b0;
			end
		end else if (hdr_pos == POS_HUNT) begin
			hdr_pos = hunt_restart(b);
		end else if (hdr_pos == POS_TAG) begin
			hdr_pos = (b == TAG_BYTE) ? POS_CHAN : hunt_restart(b);
		end else if (hdr_pos == POS_CHAN) begin
			// lowercase hex only; channel updates on this very byte
			if (b >= CHR_0 && b <= CHR_9) begin
				cur_chan = CHAN_W'(b - CHR_0);
				hdr_pos = POS_LEN0;
			end else if (b >= CHR_A && b <= CHR_F) begin
				cur_chan = CHAN_W'(b - CHR_A + 8'd10);
				hdr_pos = POS_LEN0;
			end else begin
				hdr_pos = hunt_restart(b);
			end
		end else if (hdr_pos <= POS_LAST && b >= CHR_0 && b <= CHR_9) begin
			acc = (hdr_pos == POS_LEN0) ? 0 : int'(frame_len);
			acc = acc * 10 + int'(b - CHR_0);
			if (acc > int'(LEN_MAX))
				acc = int'(LEN_MAX);
			frame_len = LEN_W'(acc);
			if (hdr_pos == POS_LAST) begin
				// zero length closes the frame right here
				hdr_pos = POS_HUNT;
				frame_cnt = '0;
				in_frame = (frame_len != '0);
			end else begin
				hdr_pos = hdr_pos + 1'b1;
			end
		end else begin
			hdr_pos = hunt_restart(b);
		end
		r.chan = cur_chan;
		return r;
	endfunction

	// Header-ish bytes, weighted so the hunt sees lots of near misses
	function automatic logic [BYTE_W-1:0] noise_pick();
		case ($urandom_range(11))
		0, 1: return ESC_BYTE;
		2: return TAG_BYTE;
		3: return CHR_UPPER_A + BYTE_W'($urandom_range(5));
		4: return CHR_SLASH;
		5: return CHR_COLON;
		6: return CHR_BACKTICK;
		7: return CHR_G;
		8: return CHR_0 + BYTE_W'($urandom_range(9));
		9: return CHR_A + BYTE_W'($urandom_range(5));
		default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	// A byte that is guaranteed wrong at the given header index
	function automatic logic [BYTE_W-1:0] misfit_byte(input int idx);
		logic [BYTE_W-1:0] b;
		bit                fits;
		do begin
			b = noise_pick();
			case (idx)
			POS_HUNT: fits = (b == ESC_BYTE);
			POS_TAG: fits = (b == TAG_BYTE);
			POS_CHAN: fits = (b >= CHR_0 && b <= CHR_9) || (b >= CHR_A && b <= CHR_F);
			default: fits = (b >= CHR_0 && b <= CHR_9);
			endcase
		end while (fits);
		return b;
	endfunction

	// One input transfer; valid stays up until it is taken
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		deframed_q.push_back(deframe_byte(b));
		sent_items++;
	endtask

	// Header plus payload; with break_at >= 0 that header byte is spoiled and
	// no payload follows
	task automatic send_frame(input int chan, input int len, input int break_at);
		logic [BYTE_W-1:0] hdr[HDR_BYTES];
		int                scale;
		hdr[0] = ESC_BYTE;
		hdr[1] = TAG_BYTE;
		hdr[2] = (chan < 10) ? CHR_0 + BYTE_W'(chan) : CHR_A + BYTE_W'(chan - 10);
		scale = 1;
		for (int k = HDR_BYTES - 1; k >= 3; k--) begin
			hdr[k] = CHR_0 + BYTE_W'((len / scale) % 10);
			scale *= 10;
		end
		if (break_at >= 0)
			hdr[break_at] = misfit_byte(break_at);
		foreach (hdr[i])
			send_byte(hdr[i]);
		if (break_at < 0)
			for (int i = 0; i < len; i++)
				send_byte(($urandom_range(3) == 0) ? noise_pick() : BYTE_W'($urandom_range(255)));
	endtask

	// Sender stays quiet until every queued transfer has come out
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (deframed_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_header_hunt();
		logic [BYTE_W-1:0] seq[$];
		idle_pct = 0;
		stall_pct = 0;
		seq = '{8'h00, 8'hFF,
			// ESC while waiting for the tag re-arms; uppercase channel rejected
			ESC_BYTE, ESC_BYTE, TAG_BYTE, CHR_UPPER_A,
			// zero-length frame on channel f, next byte already hunts
			ESC_BYTE, TAG_BYTE, CHR_F, CHR_0, CHR_0, CHR_0, CHR_0,
			// two payload bytes, the first one ESC
			ESC_BYTE, TAG_BYTE, CHR_9, CHR_0, CHR_0, CHR_0, CHR_0 + 8'd2, ESC_BYTE, 8'hFF,
			// non-digit in the length keeps the channel
			ESC_BYTE, TAG_BYTE, CHR_A, CHR_COLON};
		foreach (seq[i])
			send_byte(seq[i]);
		wait_drain();
	endtask

	// Output held off for a long stretch while the sender keeps pushing
	task automatic test_output_holdoff();
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		send_frame($urandom_range(15), $urandom_range(60, 40), -1);
		wait_drain();
	endtask

	// Longer than an 8- or 9-bit counter can track
	task automatic test_long_frame();
		idle_pct = 22;
		stall_pct = 22;
		send_frame($urandom_range(15), $urandom_range(599, 520), -1);
		wait_drain();
	endtask

	task automatic test_random_traffic();
		int phase_idle[4]  = '{0, 58, 0, 22};
		int phase_stall[4] = '{0, 0, 58, 22};
		int start;
		int pick;
		int len;
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			start = sent_items;
			while (sent_items - start < RANDOM_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					pick = $urandom_range(99);
					if (pick < 60)
						len = $urandom_range(8);
					else if (pick < 90)
						len = $urandom_range(40, 9);
					else if (pick < 99)
						len = $urandom_range(150, 41);
					else
						len = $urandom_range(600, 256);
					send_frame($urandom_range(15), len, -1);
				end else if (pick < 85) begin
					// full-range length digits, broken somewhere in the header
					send_frame($urandom_range(15), $urandom_range(9999),
						$urandom_range(HDR_BYTES - 1));
				end else begin
					repeat ($urandom_range(6, 1))
						send_byte(noise_pick());
				end
			end
			wait_drain();
		end
	endtask

	// Receiver side: random stall, or a hold-off counted here
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLDOFF_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
		input logic [BYTE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Output checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (deframed_q.size() == 0) begin
				$display("%0t: transfer with nothing expected, expected none, actual byte %0h",
					$time, payload_byte);
				errors++;
			end else begin
				want_beat = deframed_q.pop_front();
				check_field("payload_valid", want_beat.payload, payload_valid);
				check_field("payload_byte", want_beat.data, payload_byte);
				check_field("channel_id", want_beat.chan, channel_id);
				check_field("frame_end", want_beat.last, frame_end);
			end
		end
	end

	// Watchdog on progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("bulk_data_frame_deframer_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		hdr_pos = POS_HUNT;
		in_frame = 1'b0;
		cur_chan = '0;
		frame_len = '0;
		frame_cnt = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_hunt();
		test_output_holdoff();
		test_long_frame();
		test_random_traffic();

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("bulk_data_frame_deframer_tb: done, clean");
		else
			$display("bulk_data_frame_deframer_tb: done, errors");
		$finish;
	end

endmodule

>>> sim.f
src/bdfd_pkg.sv
src/bdfd_parse.sv
src/bulk_data_frame_deframer.sv
verif/bulk_data_frame_deframer_tb.sv
